// File: src/ivc_pkg.sv
// Shared types, widths, event and button codes, and setting tables for the
// intervalometer countdown controller. No dependencies.
package ivc_pkg;

    localparam int OP_W    = 2;
    localparam int BTN_W   = 4;
    localparam int SET_W   = 8;
    localparam int DIG_W   = 7;
    localparam int SHOT_W  = 7;
    localparam int SEL_W   = 3;
    localparam int NUM_SET = 8;
    localparam int NUM_DIG = 4;
    localparam int DELAY_W = 10;
    localparam int REM_W   = 16;
    localparam int DELAY_SHIFT = 2;

    // event kinds
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS = 2'd1;
    localparam logic [OP_W-1:0] OP_EXT   = 2'd2;

    // button mask bits
    localparam int BTN_ARM  = 0;
    localparam int BTN_NEXT = 1;
    localparam int BTN_EDIT = 2;
    localparam int BTN_PREV = 3;

    // setting indexes
    localparam logic [SEL_W-1:0] IDX_HOURS = 3'd0;
    localparam logic [SEL_W-1:0] IDX_DEKA  = 3'd1;
    localparam logic [SEL_W-1:0] IDX_MIN   = 3'd2;
    localparam logic [SEL_W-1:0] IDX_DECI  = 3'd3;
    localparam logic [SEL_W-1:0] IDX_COUNT = 3'd4;
    localparam logic [SEL_W-1:0] IDX_EXT   = 3'd5;
    localparam logic [SEL_W-1:0] IDX_TRIG  = 3'd6;
    localparam logic [SEL_W-1:0] IDX_AUX   = 3'd7;

    localparam logic [SEL_W-1:0] SEL_RESET = IDX_MIN;

    // countdown digit weights in deci-minutes
    localparam logic [REM_W-1:0] W_HOURS = 16'd600;
    localparam logic [REM_W-1:0] W_DEKA  = 16'd100;
    localparam logic [REM_W-1:0] W_MIN   = 16'd10;

    typedef logic [NUM_SET-1:0][SET_W-1:0] t_set_arr;
    typedef logic [NUM_DIG-1:0][DIG_W-1:0] t_dig_arr;

    // listed from index 7 down to index 0
    localparam t_set_arr SET_MAX   = {8'd255, 8'd255, 8'd1, 8'd99, 8'd9, 8'd9, 8'd5, 8'd99};
    localparam t_set_arr SET_RESET = {8'd0, 8'd102, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BTN_W-1:0] buttons;
    } t_in;

    typedef struct packed {
        logic               capture_start;
        logic [DELAY_W-1:0] shutter_ticks;
        logic [DELAY_W-1:0] aux_ticks;
        logic               ext_enable;
        logic               activity_flash;
        logic               armed_flag;
        logic               running_flag;
        logic               editing_flag;
        logic [SEL_W-1:0]   selected_index;
        logic [SET_W-1:0]   selected_value;
        logic [REM_W-1:0]   remaining_deci_minutes;
        logic [SHOT_W-1:0]  remaining_shots;
    } t_res;

endpackage

// File: src/ivc_if.sv
// Channel interfaces for the event input and the status output.
// Depends on ivc_pkg for field widths.
interface ivc_in_if;
    logic                       valid;
    logic                       ready;
    logic [ivc_pkg::OP_W-1:0]   op;
    logic [ivc_pkg::BTN_W-1:0]  buttons;

    modport source (output valid, output op, output buttons, input ready);
    modport sink   (input valid, input op, input buttons, output ready);
endinterface

interface ivc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           capture_start;
    logic [ivc_pkg::DELAY_W-1:0]    shutter_ticks;
    logic [ivc_pkg::DELAY_W-1:0]    aux_ticks;
    logic                           ext_enable;
    logic                           activity_flash;
    logic                           armed_flag;
    logic                           running_flag;
    logic                           editing_flag;
    logic [ivc_pkg::SEL_W-1:0]      selected_index;
    logic [ivc_pkg::SET_W-1:0]      selected_value;
    logic [ivc_pkg::REM_W-1:0]      remaining_deci_minutes;
    logic [ivc_pkg::SHOT_W-1:0]     remaining_shots;

    modport source (
        output valid, input ready,
        output capture_start, output shutter_ticks, output aux_ticks, output ext_enable,
        output activity_flash, output armed_flag, output running_flag, output editing_flag,
        output selected_index, output selected_value, output remaining_deci_minutes,
        output remaining_shots
    );
    modport sink (
        input valid, output ready,
        input capture_start, input shutter_ticks, input aux_ticks, input ext_enable,
        input activity_flash, input armed_flag, input running_flag, input editing_flag,
        input selected_index, input selected_value, input remaining_deci_minutes,
        input remaining_shots
    );
endinterface

// File: src/intervalometer_countdown_controller.sv
// Intervalometer countdown controller top level: input register, step core,
// result register. Depends on ivc_pkg, ivc_in_if/ivc_out_if and the ivc_* modules.
//
// Usage:
//   i_in carries one event per beat: op (period tick, button press, external
//   trigger edge) and the button mask. o_out returns exactly one status beat
//   per event: capture start with shutter and aux delays, mode flags, the
//   selected setting and the remaining countdown and shots.
//   The input register captures each accepted event, and the step result is
//   written into the result register when that register is free.
//   Throughput is one event per cycle while the receiver does not stall; the
//   state update for an event is a single pass of combinational logic, so
//   the next event follows at once.
//   When the receiver stalls, the result register holds its beat, the core
//   stops, and the input register fills and then drops i_in.ready; nothing
//   is lost. Synchronous reset loads the default settings (one minute,
//   shutter delay 102), clears the countdown, shots and mode bits, selects
//   the minutes setting, and empties both registers.
module intervalometer_countdown_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ivc_in_if.sink          i_in,
    ivc_out_if.source       o_out
);
    ivc_pkg::t_in  in_data;
    ivc_pkg::t_in  stage_data;
    ivc_pkg::t_res core_res;
    ivc_pkg::t_res out_res;
    logic          stage_valid;
    logic          advance;
    logic          fire;

    assign in_data.op      = i_in.op;
    assign in_data.buttons = i_in.buttons;
    assign fire            = stage_valid && advance;

    ivc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_data    (in_data),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (stage_valid),
        .o_data    (stage_data)
    );

    ivc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_data  (stage_data),
        .o_res   (core_res)
    );

    ivc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (stage_valid),
        .i_res   (core_res),
        .i_ready (o_out.ready),
        .o_free  (advance),
        .o_valid (o_out.valid),
        .o_res   (out_res)
    );

    assign o_out.capture_start          = out_res.capture_start;
    assign o_out.shutter_ticks          = out_res.shutter_ticks;
    assign o_out.aux_ticks              = out_res.aux_ticks;
    assign o_out.ext_enable             = out_res.ext_enable;
    assign o_out.activity_flash         = out_res.activity_flash;
    assign o_out.armed_flag             = out_res.armed_flag;
    assign o_out.running_flag           = out_res.running_flag;
    assign o_out.editing_flag           = out_res.editing_flag;
    assign o_out.selected_index         = out_res.selected_index;
    assign o_out.selected_value         = out_res.selected_value;
    assign o_out.remaining_deci_minutes = out_res.remaining_deci_minutes;
    assign o_out.remaining_shots        = out_res.remaining_shots;

    // a capture only happens on a tick while armed
    a_cap_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.capture_start |-> o_out.activity_flash)
        else $error("capture without activity flash");

    // the countdown never runs while disarmed
    a_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.running_flag |-> o_out.armed_flag)
        else $error("running while disarmed");

    // delays are reported only with a capture
    a_delay_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.capture_start |->
            (o_out.shutter_ticks == '0) && (o_out.aux_ticks == '0))
        else $error("delay without capture");

    // a beat moving through the core always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out.valid)
        else $error("processed event lost");
endmodule

// File: src/ivc_in_reg.sv
// Input register stage: holds one event beat until the core consumes it.
// Depends on ivc_pkg.
module ivc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ivc_pkg::t_in  i_data,
    input  logic          i_advance,
    output logic          o_ready,
    output logic          o_valid,
    output ivc_pkg::t_in  o_data
);
    logic         r_valid;
    ivc_pkg::t_in r_data;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end
endmodule

// File: src/ivc_core.sv
// Controller state (settings, countdown digits, shots, mode bits) and the
// single-pass step logic that produces the next state and status. Uses ivc_pkg.
module ivc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  ivc_pkg::t_in   i_data,
    output ivc_pkg::t_res  o_res
);
    ivc_pkg::t_set_arr               r_set, n_set;
    ivc_pkg::t_dig_arr               r_dig, n_dig;
    logic [ivc_pkg::SHOT_W-1:0]      r_shots, n_shots;
    logic                            r_armed, n_armed;
    logic                            r_running, n_running;
    logic                            r_editing, n_editing;
    logic [ivc_pkg::SEL_W-1:0]       r_sel, n_sel;

    always_comb begin
        logic                       done;
        logic                       cap;
        logic                       flash;
        logic                       time_zero;
        logic [ivc_pkg::SET_W-1:0]  cur;

        n_set     = r_set;
        n_dig     = r_dig;
        n_shots   = r_shots;
        n_armed   = r_armed;
        n_running = r_running;
        n_editing = r_editing;
        n_sel     = r_sel;
        done      = 1'b0;
        cap       = 1'b0;
        flash     = 1'b0;
        time_zero = (r_set[ivc_pkg::IDX_HOURS] == '0) && (r_set[ivc_pkg::IDX_DEKA] == '0) &&
                    (r_set[ivc_pkg::IDX_MIN] == '0) && (r_set[ivc_pkg::IDX_DECI] == '0);
        cur       = '0;

        case (i_data.op)
            ivc_pkg::OP_TICK: begin
                if (r_armed) begin
                    flash = 1'b1;
                    if (r_running) begin
                        // borrow from the least significant digit upward
                        for (int i = ivc_pkg::NUM_DIG - 1; i >= 0; i--) begin
                            if (!done) begin
                                if (n_dig[i] != '0) begin
                                    n_dig[i] = n_dig[i] - 1'b1;
                                    done     = 1'b1;
                                end else begin
                                    n_dig[i] = ivc_pkg::SET_MAX[i][ivc_pkg::DIG_W-1:0];
                                end
                            end
                        end
                        if (n_dig == '0) begin
                            cap = 1'b1;
                            if (r_set[ivc_pkg::IDX_COUNT] != '0) begin
                                n_shots = r_shots - 1'b1;
                                if (n_shots == '0) begin
                                    n_running = 1'b0;
                                    n_armed   = (r_set[ivc_pkg::IDX_EXT] != '0);
                                end
                            end else begin
                                n_running = (r_set[ivc_pkg::IDX_EXT] == '0);
                            end
                            for (int i = 0; i < ivc_pkg::NUM_DIG; i++) begin
                                n_dig[i] = r_set[i][ivc_pkg::DIG_W-1:0];
                            end
                        end
                    end
                end
            end
            ivc_pkg::OP_PRESS: begin
                if (i_data.buttons[ivc_pkg::BTN_ARM]) begin
                    n_armed   = !r_armed;
                    n_running = n_armed && (r_set[ivc_pkg::IDX_EXT] == '0) && !time_zero;
                    for (int i = 0; i < ivc_pkg::NUM_DIG; i++) begin
                        n_dig[i] = r_set[i][ivc_pkg::DIG_W-1:0];
                    end
                    n_shots = r_set[ivc_pkg::IDX_COUNT][ivc_pkg::SHOT_W-1:0];
                    if (n_running) begin
                        n_editing = 1'b0;
                    end
                end
                // remaining bits act only while disarmed, edit then prev then next
                if (!n_armed) begin
                    if (i_data.buttons[ivc_pkg::BTN_EDIT]) begin
                        n_editing = !n_editing;
                    end
                    if (i_data.buttons[ivc_pkg::BTN_PREV]) begin
                        if (n_editing) begin
                            cur = n_set[n_sel];
                            if (cur < ivc_pkg::SET_MAX[n_sel]) begin
                                n_set[n_sel] = cur + 1'b1;
                            end
                        end else begin
                            n_sel = n_sel - 1'b1;
                        end
                    end
                    if (i_data.buttons[ivc_pkg::BTN_NEXT]) begin
                        if (n_editing) begin
                            cur = n_set[n_sel];
                            if (cur != '0) begin
                                n_set[n_sel] = cur - 1'b1;
                            end
                        end else begin
                            n_sel = n_sel + 1'b1;
                        end
                    end
                end
            end
            ivc_pkg::OP_EXT: begin
                if (r_armed && !r_running && (r_set[ivc_pkg::IDX_EXT] != '0)) begin
                    n_running = 1'b1;
                    for (int i = 0; i < ivc_pkg::NUM_DIG; i++) begin
                        n_dig[i] = r_set[i][ivc_pkg::DIG_W-1:0];
                    end
                    n_shots = r_set[ivc_pkg::IDX_COUNT][ivc_pkg::SHOT_W-1:0];
                    if (n_shots == '0) begin
                        n_shots = ivc_pkg::SHOT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        o_res.capture_start  = cap;
        o_res.shutter_ticks  = cap ? (ivc_pkg::DELAY_W'(r_set[ivc_pkg::IDX_TRIG])
                                      << ivc_pkg::DELAY_SHIFT) : '0;
        o_res.aux_ticks      = cap ? (ivc_pkg::DELAY_W'(r_set[ivc_pkg::IDX_AUX])
                                      << ivc_pkg::DELAY_SHIFT) : '0;
        o_res.ext_enable     = n_armed && (n_set[ivc_pkg::IDX_EXT] != '0);
        o_res.activity_flash = flash;
        o_res.armed_flag     = n_armed;
        o_res.running_flag   = n_running;
        o_res.editing_flag   = n_editing;
        o_res.selected_index = n_sel;
        o_res.selected_value = n_set[n_sel];
        o_res.remaining_deci_minutes =
            ivc_pkg::REM_W'(n_dig[ivc_pkg::IDX_HOURS]) * ivc_pkg::W_HOURS +
            ivc_pkg::REM_W'(n_dig[ivc_pkg::IDX_DEKA]) * ivc_pkg::W_DEKA +
            ivc_pkg::REM_W'(n_dig[ivc_pkg::IDX_MIN]) * ivc_pkg::W_MIN +
            ivc_pkg::REM_W'(n_dig[ivc_pkg::IDX_DECI]);
        o_res.remaining_shots = n_shots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set     <= ivc_pkg::SET_RESET;
            r_dig     <= '0;
            r_shots   <= '0;
            r_armed   <= 1'b0;
            r_running <= 1'b0;
            r_editing <= 1'b0;
            r_sel     <= ivc_pkg::SEL_RESET;
        end else if (i_fire) begin
            r_set     <= n_set;
            r_dig     <= n_dig;
            r_shots   <= n_shots;
            r_armed   <= n_armed;
            r_running <= n_running;
            r_editing <= n_editing;
            r_sel     <= n_sel;
        end
    end
endmodule

// File: src/ivc_out_reg.sv
// Result register: holds one status beat until the receiver takes it.
// Depends on ivc_pkg.
module ivc_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ivc_pkg::t_res  i_res,
    input  logic           i_ready,
    output logic           o_free,
    output logic           o_valid,
    output ivc_pkg::t_res  o_res
);
    logic          r_valid;
    ivc_pkg::t_res r_res;

    // slot can take a new beat when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end
endmodule

// File: test/intervalometer_countdown_controller_test.sv
// Self-checking testbench for the intervalometer countdown controller: directed
// event table, then random edit, arm and noise sequences checked against a predictor.
// Depends on ivc_pkg, ivc_in_if/ivc_out_if and the intervalometer_countdown_controller RTL.
module intervalometer_countdown_controller_test;

    localparam logic [ivc_pkg::OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [ivc_pkg::BTN_W-1:0] B_ARM  = 4'(1 << ivc_pkg::BTN_ARM);
    localparam logic [ivc_pkg::BTN_W-1:0] B_NEXT = 4'(1 << ivc_pkg::BTN_NEXT);
    localparam logic [ivc_pkg::BTN_W-1:0] B_EDIT = 4'(1 << ivc_pkg::BTN_EDIT);
    localparam logic [ivc_pkg::BTN_W-1:0] B_PREV = 4'(1 << ivc_pkg::BTN_PREV);

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;

    // mode bits: armed, running, editing
    typedef struct packed {
        logic [ivc_pkg::OP_W-1:0]  op;
        logic [ivc_pkg::BTN_W-1:0] btn;
        logic [7:0]                reps;
        logic                      pin;
        logic [ivc_pkg::SEL_W-1:0] sel;
        logic [ivc_pkg::SET_W-1:0] val;
        logic [2:0]                mode;
    } t_row;

    localparam t_row DIRECTED [27] = '{
        '{ivc_pkg::OP_TICK,  4'h0, 8'd1, 1'b1, ivc_pkg::IDX_MIN, 8'd1, 3'b000},
        '{OP_UNUSED,         4'hF, 8'd1, 1'b1, ivc_pkg::IDX_MIN, 8'd1, 3'b000},
        '{ivc_pkg::OP_PRESS, B_EDIT, 8'd1, 1'b1, ivc_pkg::IDX_MIN, 8'd1, 3'b001},
        '{ivc_pkg::OP_PRESS, B_NEXT, 8'd2, 1'b1, ivc_pkg::IDX_MIN, 8'd0, 3'b001},
        '{ivc_pkg::OP_PRESS, B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_MIN, 8'd0, 3'b101},
        '{ivc_pkg::OP_EXT,   4'h0, 8'd1, 1'b1, ivc_pkg::IDX_MIN, 8'd0, 3'b101},
        '{ivc_pkg::OP_PRESS, 4'hF, 8'd1, 1'b1, ivc_pkg::IDX_MIN, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_NEXT, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_EDIT | B_PREV, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd1, 3'b001},
        '{ivc_pkg::OP_PRESS, B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd1, 3'b110},
        '{ivc_pkg::OP_PRESS, B_NEXT | B_EDIT | B_PREV, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd1,
          3'b110},
        '{ivc_pkg::OP_TICK,  4'h0, 8'd1, 1'b0, ivc_pkg::IDX_DECI, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd1, 3'b000},
        '{ivc_pkg::OP_PRESS, B_NEXT, 8'd2, 1'b0, ivc_pkg::IDX_EXT, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_EDIT | B_PREV, 8'd1, 1'b1, ivc_pkg::IDX_EXT, 8'd1, 3'b001},
        '{ivc_pkg::OP_PRESS, B_PREV, 8'd1, 1'b1, ivc_pkg::IDX_EXT, 8'd1, 3'b001},
        '{ivc_pkg::OP_PRESS, B_EDIT, 8'd1, 1'b1, ivc_pkg::IDX_EXT, 8'd1, 3'b000},
        '{ivc_pkg::OP_PRESS, B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_EXT, 8'd1, 3'b100},
        '{ivc_pkg::OP_EXT,   4'h0, 8'd1, 1'b0, ivc_pkg::IDX_EXT, 8'd0, 3'b000},
        '{ivc_pkg::OP_TICK,  4'h0, 8'd1, 1'b0, ivc_pkg::IDX_EXT, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_EXT, 8'd1, 3'b000},
        '{ivc_pkg::OP_PRESS, B_PREV, 8'd2, 1'b0, ivc_pkg::IDX_DECI, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_EDIT | B_NEXT, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd0, 3'b001},
        '{ivc_pkg::OP_PRESS, B_EDIT | B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd0, 3'b101},
        '{ivc_pkg::OP_EXT,   4'h0, 8'd1, 1'b0, ivc_pkg::IDX_DECI, 8'd0, 3'b000},
        '{ivc_pkg::OP_TICK,  4'h0, 8'd1, 1'b0, ivc_pkg::IDX_DECI, 8'd0, 3'b000},
        '{ivc_pkg::OP_PRESS, B_ARM, 8'd1, 1'b1, ivc_pkg::IDX_DECI, 8'd0, 3'b001}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ivc_in_if  ev_ch ();
    ivc_out_if st_ch ();

    intervalometer_countdown_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_ch),
        .o_out   (st_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted controller state
    logic [ivc_pkg::SET_W-1:0]  pr_setting [ivc_pkg::NUM_SET];
    logic [ivc_pkg::DIG_W-1:0]  pr_digit [ivc_pkg::NUM_DIG];
    logic [ivc_pkg::SHOT_W-1:0] pr_shots;
    logic                       pr_armed;
    logic                       pr_running;
    logic                       pr_editing;
    logic [ivc_pkg::SEL_W-1:0]  pr_sel;

    ivc_pkg::t_res expected_status [$];
    int   n_sent = 0;
    int   n_bad = 0;
    int   n_cycles = 0;
    int   burst_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic string status_text(ivc_pkg::t_res s);
        return $sformatf({"cap=%0d trig=%0d aux=%0d ext=%0d flash=%0d arm=%0d run=%0d ",
                          "edit=%0d sel=%0d val=%0d rem=%0d shots=%0d"},
                         s.capture_start, s.shutter_ticks, s.aux_ticks, s.ext_enable,
                         s.activity_flash, s.armed_flag, s.running_flag, s.editing_flag,
                         s.selected_index, s.selected_value, s.remaining_deci_minutes,
                         s.remaining_shots);
    endfunction

    task automatic note_failure(input string what);
        n_bad++;
        if (n_bad <= 10) $display("%s", what);
    endtask

    task automatic load_countdown();
        for (int i = 0; i < ivc_pkg::NUM_DIG; i++)
            pr_digit[i] = pr_setting[i][ivc_pkg::DIG_W-1:0];
    endtask

    task automatic step_controller(input logic [ivc_pkg::OP_W-1:0] op,
                                   input logic [ivc_pkg::BTN_W-1:0] btn,
                                   output ivc_pkg::t_res st);
        logic borrow;
        st = '0;
        case (op)
            ivc_pkg::OP_TICK: if (pr_armed) begin
                st.activity_flash = 1'b1;
                if (pr_running) begin
                    borrow = 1'b1;
                    for (int i = ivc_pkg::NUM_DIG - 1; i >= 0; i--) begin
                        if (borrow) begin
                            if (pr_digit[i] != 0) begin
                                pr_digit[i] = pr_digit[i] - 1'b1;
                                borrow = 1'b0;
                            end else begin
                                pr_digit[i] = ivc_pkg::SET_MAX[i][ivc_pkg::DIG_W-1:0];
                            end
                        end
                    end
                    if ((pr_digit[0] | pr_digit[1] | pr_digit[2] | pr_digit[3]) == 0) begin
                        st.capture_start = 1'b1;
                        st.shutter_ticks = {pr_setting[ivc_pkg::IDX_TRIG], 2'b00};
                        st.aux_ticks = {pr_setting[ivc_pkg::IDX_AUX], 2'b00};
                        if (pr_setting[ivc_pkg::IDX_COUNT] != 0) begin
                            pr_shots = pr_shots - 1'b1;
                            if (pr_shots == 0) begin
                                pr_running = 1'b0;
                                pr_armed = pr_setting[ivc_pkg::IDX_EXT] != 0;
                            end
                        end else begin
                            pr_running = pr_setting[ivc_pkg::IDX_EXT] == 0;
                        end
                        load_countdown();
                    end
                end
            end
            ivc_pkg::OP_PRESS: begin
                if (btn[ivc_pkg::BTN_ARM]) begin
                    pr_armed = !pr_armed;
                    pr_running = pr_armed && pr_setting[ivc_pkg::IDX_EXT] == 0;
                    load_countdown();
                    pr_shots = pr_setting[ivc_pkg::IDX_COUNT][ivc_pkg::SHOT_W-1:0];
                    // an all-zero time never starts
                    if ((pr_setting[0] | pr_setting[1] | pr_setting[2] | pr_setting[3]) == 0)
                        pr_running = 1'b0;
                    if (pr_running) pr_editing = 1'b0;
                end
                if (!pr_armed) begin
                    if (btn[ivc_pkg::BTN_EDIT]) pr_editing = !pr_editing;
                    if (btn[ivc_pkg::BTN_PREV]) begin
                        if (!pr_editing) pr_sel = pr_sel - 1'b1;
                        else if (pr_setting[pr_sel] < ivc_pkg::SET_MAX[pr_sel])
                            pr_setting[pr_sel] = pr_setting[pr_sel] + 1'b1;
                    end
                    if (btn[ivc_pkg::BTN_NEXT]) begin
                        if (!pr_editing) pr_sel = pr_sel + 1'b1;
                        else if (pr_setting[pr_sel] > 0)
                            pr_setting[pr_sel] = pr_setting[pr_sel] - 1'b1;
                    end
                end
            end
            ivc_pkg::OP_EXT: if (pr_armed && !pr_running
                                 && pr_setting[ivc_pkg::IDX_EXT] != 0) begin
                pr_running = 1'b1;
                load_countdown();
                pr_shots = pr_setting[ivc_pkg::IDX_COUNT][ivc_pkg::SHOT_W-1:0];
                if (pr_shots == 0) pr_shots = ivc_pkg::SHOT_W'(1);
            end
            default: ;
        endcase
        st.ext_enable = pr_armed && pr_setting[ivc_pkg::IDX_EXT] != 0;
        st.armed_flag = pr_armed;
        st.running_flag = pr_running;
        st.editing_flag = pr_editing;
        st.selected_index = pr_sel;
        st.selected_value = pr_setting[pr_sel];
        st.remaining_deci_minutes = ivc_pkg::W_HOURS * ivc_pkg::REM_W'(pr_digit[0])
                                    + ivc_pkg::W_DEKA * ivc_pkg::REM_W'(pr_digit[1])
                                    + ivc_pkg::W_MIN * ivc_pkg::REM_W'(pr_digit[2])
                                    + ivc_pkg::REM_W'(pr_digit[3]);
        st.remaining_shots = pr_shots;
    endtask

    // offer one event, wait until it is accepted, then record the status it must produce
    task automatic send_event(input logic [ivc_pkg::OP_W-1:0] op,
                              input logic [ivc_pkg::BTN_W-1:0] btn,
                              input logic pin = 1'b0,
                              input logic [ivc_pkg::SEL_W-1:0] sel = '0,
                              input logic [ivc_pkg::SET_W-1:0] val = '0,
                              input logic [2:0] mode = '0);
        int            gap;
        ivc_pkg::t_res st;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 100);
        end
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.op <= op;
        ev_ch.buttons <= btn;
        @(posedge i_clk);
        while (!ev_ch.ready) @(posedge i_clk);
        n_sent++;
        step_controller(op, btn, st);
        if (pin) begin
            st.selected_index = sel;
            st.selected_value = val;
            {st.armed_flag, st.running_flag, st.editing_flag} = mode;
        end
        expected_status.push_back(st);
    endtask

    task automatic edit_setting(input logic [ivc_pkg::SEL_W-1:0] idx, input bit up,
                                input int n);
        bit walk_up;
        walk_up = 1'($urandom_range(0, 1));
        if (pr_armed) send_event(ivc_pkg::OP_PRESS, B_ARM);
        if (pr_editing) send_event(ivc_pkg::OP_PRESS, B_EDIT);
        while (pr_sel != idx) send_event(ivc_pkg::OP_PRESS, walk_up ? B_PREV : B_NEXT);
        send_event(ivc_pkg::OP_PRESS, B_EDIT);
        repeat (n) send_event(ivc_pkg::OP_PRESS, up ? B_PREV : B_NEXT);
        if ($urandom_range(0, 1)) send_event(ivc_pkg::OP_PRESS, B_EDIT);
    endtask

    task automatic run_countdown();
        int r;
        if (pr_setting[ivc_pkg::IDX_HOURS] != 0 && $urandom_range(0, 3) != 0)
            edit_setting(ivc_pkg::IDX_HOURS, 1'b0, int'(pr_setting[ivc_pkg::IDX_HOURS]));
        if (pr_setting[ivc_pkg::IDX_DEKA] != 0 && $urandom_range(0, 3) != 0)
            edit_setting(ivc_pkg::IDX_DEKA, 1'b0, int'(pr_setting[ivc_pkg::IDX_DEKA]));
        if ($urandom_range(0, 2) == 0)
            edit_setting($urandom_range(0, 1) ? ivc_pkg::IDX_MIN : ivc_pkg::IDX_DECI,
                         1'($urandom_range(0, 1)), int'($urandom_range(1, 3)));
        if ($urandom_range(0, 3) == 0)
            edit_setting(ivc_pkg::IDX_EXT, 1'($urandom_range(0, 1)), 1);
        if ($urandom_range(0, 3) == 0)
            edit_setting(ivc_pkg::IDX_COUNT, $urandom_range(0, 2) != 0,
                         int'($urandom_range(1, 3)));
        if (pr_armed) send_event(ivc_pkg::OP_PRESS, B_ARM);
        // extra bits on the arming press are dropped
        send_event(ivc_pkg::OP_PRESS, 4'($urandom_range(0, 15)) | B_ARM);
        if (pr_setting[ivc_pkg::IDX_EXT] != 0) begin
            repeat ($urandom_range(0, 3))
                send_event(ivc_pkg::OP_TICK, 4'($urandom_range(0, 15)));
            send_event(ivc_pkg::OP_EXT, 4'($urandom_range(0, 15)));
        end
        repeat ($urandom_range(1, 120)) begin
            r = $urandom_range(0, 99);
            if (r < 85) send_event(ivc_pkg::OP_TICK, 4'($urandom_range(0, 15)));
            else if (r < 90) send_event(ivc_pkg::OP_EXT, 4'($urandom_range(0, 15)));
            else send_event(ivc_pkg::OP_PRESS, 4'($urandom_range(0, 15)) & ~B_ARM);
        end
    endtask

    // receiver side: random ready gaps plus one long hold-off
    initial begin : status_ready
        int  hold;
        bit  long_done;
        long_done = 1'b0;
        st_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!long_done && n_sent >= 500) begin
                long_done = 1'b1;
                st_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            hold = pick_gap();
            if (hold > 0) begin
                st_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            st_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0) repeat ($urandom_range(100, 300)) @(posedge i_clk);
            else repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : status_check
        ivc_pkg::t_res got;
        ivc_pkg::t_res want;
        if (i_rst_n && st_ch.valid && st_ch.ready) begin
            got.capture_start = st_ch.capture_start;
            got.shutter_ticks = st_ch.shutter_ticks;
            got.aux_ticks = st_ch.aux_ticks;
            got.ext_enable = st_ch.ext_enable;
            got.activity_flash = st_ch.activity_flash;
            got.armed_flag = st_ch.armed_flag;
            got.running_flag = st_ch.running_flag;
            got.editing_flag = st_ch.editing_flag;
            got.selected_index = st_ch.selected_index;
            got.selected_value = st_ch.selected_value;
            got.remaining_deci_minutes = st_ch.remaining_deci_minutes;
            got.remaining_shots = st_ch.remaining_shots;
            if (expected_status.size() == 0) begin
                note_failure({"unexpected status beat: ", status_text(got)});
            end else begin
                want = expected_status.pop_front();
                if (got !== want)
                    note_failure({"status mismatch\n  exp ", status_text(want),
                                  "\n  got ", status_text(got)});
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : event_source
        int rnd_start;
        int r;
        i_rst_n = 1'b0;
        ev_ch.valid = 1'b0;
        ev_ch.op = ivc_pkg::OP_TICK;
        ev_ch.buttons = '0;
        for (int i = 0; i < ivc_pkg::NUM_SET; i++) pr_setting[i] = ivc_pkg::SET_RESET[i];
        for (int i = 0; i < ivc_pkg::NUM_DIG; i++) pr_digit[i] = '0;
        pr_shots = '0;
        pr_armed = 1'b0;
        pr_running = 1'b0;
        pr_editing = 1'b0;
        pr_sel = ivc_pkg::SEL_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k])
            repeat (DIRECTED[k].reps)
                send_event(DIRECTED[k].op, DIRECTED[k].btn, DIRECTED[k].pin,
                           DIRECTED[k].sel, DIRECTED[k].val, DIRECTED[k].mode);

        rnd_start = n_sent;
        while (n_sent - rnd_start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                // mostly small steps, now and then a long run to hit the limits
                r = $urandom_range(0, 7);
                edit_setting(ivc_pkg::SEL_W'(r),
                             (r < 2) ? ($urandom_range(0, 4) == 0)
                                     : 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 9) == 0) ? int'($urandom_range(100, 260))
                                                         : int'($urandom_range(1, 6)));
            end else if (r < 70) begin
                run_countdown();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_event(ivc_pkg::OP_W'($urandom_range(0, 3)),
                               4'($urandom_range(0, 15)));
            end
        end

        ev_ch.valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_bad == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
src/ivc_pkg.sv
src/ivc_if.sv
src/ivc_in_reg.sv
src/ivc_core.sv
src/ivc_out_reg.sv
src/intervalometer_countdown_controller.sv
test/intervalometer_countdown_controller_test.sv
